// File: src/assert_macros.svh
// assertion macros shared by the list unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define OLID_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("olid assertion failed");

// consequence that must hold in the cycle after the antecedent
`define OLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olid assertion failed");

`endif

// File: src/olid_pkg.sv
// shared constants, codes and types of the ordered list unit
`default_nettype none

package olid_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 7;
  localparam int unsigned POS_W = 7;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              write;
    logic              shift_up;
    logic              shift_down;
    logic [IDX_W-1:0]  tgt;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/olid_cell.sv
// one entry of the list: holds a byte and moves it to or from its neighbors
`default_nettype none

module olid_cell (
  input  logic                      clk_i,
  input  logic [olid_pkg::IDX_W-1:0]  idx_i,
  input  olid_pkg::cell_cmd_t        cmd_i,
  input  logic [olid_pkg::DATA_W-1:0] left_i,
  input  logic [olid_pkg::DATA_W-1:0] right_i,
  output logic [olid_pkg::DATA_W-1:0] q_o,
  output logic [olid_pkg::DATA_W-1:0] rd_o
);
  import olid_pkg::*;

  logic [DATA_W-1:0] entry_q;
  logic [DATA_W-1:0] entry_d;
  logic              at;
  logic              above;

  assign at    = (idx_i == cmd_i.tgt);
  assign above = (idx_i > cmd_i.tgt);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.write && at) begin
      entry_d = cmd_i.data;
    end
    // insert moves everything past the target one place up
    if (cmd_i.shift_up && above) begin
      entry_d = left_i;
    end
    // delete pulls the target and everything past it one place down
    if (cmd_i.shift_down && (at || above)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  assign rd_o = at ? entry_q : '0;

endmodule

`default_nettype wire

// File: src/ordered_list_insert_delete_unit.sv
// ordered list unit: a row of entry cells with a request decoder and result register
//
// Holds an ordered list of up to 64 bytes, positions counted from 1.
// Input channel (in_valid_i / in_stall_o) carries one request word: func_i,
// position_i and data_i. func: append, insert, delete, read or clear.
// Output channel (out_valid_o / out_stall_i) carries one result word per
// request: ok_o, read_data_o, count_o, empty_res_o and full_res_o.
// Config channel (cfg_valid_i / cfg_ready_o) writes the capacity register;
// it is always ready and should be written only while the unit is idle.
// Result: the result word is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle when not stalled; every cell shifts its
// entry to a neighbor in the same cycle; insert and delete cost no more than a read.
// A read selects the addressed cell through a one-hot select over the row.
// When the receiver stalls, the result word holds and the input is stalled
// only while the result register is full and not being taken.
// Reset clears the count and the result valid and sets capacity to 64;
// the entry contents are left as they are.
`default_nettype none

module ordered_list_insert_delete_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [olid_pkg::CAP_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [olid_pkg::FUNC_W-1:0] func_i,
  input  logic [olid_pkg::POS_W-1:0]  position_i,
  input  logic [olid_pkg::DATA_W-1:0] data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [olid_pkg::DATA_W-1:0] read_data_o,
  output logic [6:0]                  count_o,
  output logic                        empty_res_o,
  output logic                        full_res_o
);
  import olid_pkg::*;

  `include "assert_macros.svh"

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              out_valid_q;
  logic              ok_q;
  logic [DATA_W-1:0] rd_q;
  logic [CNT_W-1:0]  res_count_q;
  logic              empty_q;
  logic              full_q;

  logic              in_acc;
  logic [CMP_W-1:0]  lim;
  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  pos_x;
  logic              full_now;
  logic              pos_ok;
  logic              pos_ok_ins;
  logic              ok_d;
  logic              is_read;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] rd_sel;

  logic [DATA_W-1:0] q_w  [DEPTH];
  logic [DATA_W-1:0] rd_w [DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  // effective limit is capacity clamped to the row length
  assign lim = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign cnt_x      = CMP_W'(count_q);
  assign pos_x      = CMP_W'(position_i);
  assign full_now   = (cnt_x >= lim);
  assign pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
  assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));

  always_comb begin
    cmd.write      = 1'b0;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.tgt        = IDX_W'(position_i - POS_W'(1));
    cmd.data       = data_i;
    count_d        = count_q;
    ok_d           = 1'b0;
    is_read        = 1'b0;
    unique case (func_i)
      FUNC_APPEND: begin
        cmd.tgt = IDX_W'(count_q);
        if (!full_now) begin
          cmd.write = in_acc;
          count_d   = count_q + CNT_W'(1);
          ok_d      = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (!full_now && pos_ok_ins) begin
          cmd.write    = in_acc;
          cmd.shift_up = in_acc;
          count_d      = count_q + CNT_W'(1);
          ok_d         = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (pos_ok) begin
          cmd.shift_down = in_acc;
          count_d        = count_q - CNT_W'(1);
          ok_d           = 1'b1;
        end
      end
      FUNC_READ: begin
        if (pos_ok) begin
          is_read = 1'b1;
          ok_d    = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = data_i;
    end else begin : g_mid_l
      assign left_w = q_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = q_w[k];
    end else begin : g_mid_r
      assign right_w = q_w[k+1];
    end

    olid_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(k)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (q_w[k]),
      .rd_o    (rd_w[k])
    );
  end

  // only the addressed cell drives a nonzero byte
  always_comb begin
    rd_sel = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      rd_sel = rd_sel | rd_w[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q        <= ok_d;
      rd_q        <= is_read ? rd_sel : '0;
      res_count_q <= count_d;
      empty_q     <= (count_d == '0);
      full_q      <= (CMP_W'(count_d) >= lim);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign read_data_o = rd_q;
  assign count_o     = 7'(res_count_q);
  assign empty_res_o = empty_q;
  assign full_res_o  = full_q;

  `OLID_ASSERT(a_count_bound, clk_i, rst_ni, CMP_W'(count_q) <= CMP_W'(DEPTH))
  `OLID_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_valid_q)
  `OLID_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, in_acc && (func_i == FUNC_CLEAR),
                    (count_q == '0) && empty_q)
  `OLID_ASSERT_NEXT(a_reject_keeps, clk_i, rst_ni, in_acc && !ok_d,
                    $stable(count_q))

endmodule

`default_nettype wire
